/* src/b32e_pkg.sv */
// shared types, constants and the symbol alphabet for the base32 encoder
// no dependencies; imported by every module of the block
`default_nettype none

package b32e_pkg;

	// depth of the queue between the byte front end and the symbol back end
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = QPTR_W + 1;

	// ascii of the pad character
	localparam logic [6:0] PAD_CHAR = 7'd61;

	// symbols of one byte: two data symbols plus a possible final partial one
	localparam int MAX_SYMS = 3;

	// one queued work entry: the symbols of one byte and the padding after them
	typedef struct packed {
		logic [MAX_SYMS-1:0][4:0] sym;
		logic [1:0]               nsym;
		logic [2:0]               npad;
		logic                     last;
	} b32e_entry_t;

	// standard alphabet: A-Z then 2-7
	function automatic logic [6:0] b32e_char(input logic [4:0] idx);
		logic [6:0] code;
		if (idx < 5'd26) begin
			code = 7'd65 + {2'b00, idx};
		end else begin
			code = 7'd24 + {2'b00, idx};
		end
		return code;
	endfunction

endpackage

`default_nettype wire

/* src/base32_encoder.sv */
// base32 encoder top level: byte front end, entry queue, symbol back end
// a byte's entry is registered in the queue, then its first symbol in the m_axis output register
// throughput: one symbol per cycle set by the single output register, while m_axis_tready
//   is high and the queue holds an entry; a byte gives one or two symbols, a last byte up to eight with padding
// bytes are taken back to back while the four-entry queue has room
// reset clears leftover bits, group position, queue and output valid
`default_nettype none

module base32_encoder
	import b32e_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_axis_tvalid,
	output      logic       s_axis_tready,
	input  wire logic [7:0] s_axis_tdata,   // [7:0] data_byte
	input  wire logic       s_axis_tlast,   // last_byte
	output      logic       m_axis_tvalid,
	input  wire logic       m_axis_tready,
	output      logic [7:0] m_axis_tdata,   // [6:0] symbol_char, [7] zero
	output      logic       m_axis_tlast    // last_symbol
);

	logic        push;
	logic        pop;
	logic        full;
	logic        head_valid;
	b32e_entry_t push_entry;
	b32e_entry_t head_entry;
	logic [6:0]  symbol_char;

	assign m_axis_tdata = {1'b0, symbol_char};

	b32e_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.data_byte  (s_axis_tdata),
		.last_byte  (s_axis_tlast),
		.queue_full (full),
		.push       (push),
		.push_entry (push_entry)
	);

	b32e_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.full       (full),
		.head_valid (head_valid),
		.head_entry (head_entry)
	);

	b32e_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (head_valid),
		.head_entry  (head_entry),
		.pop         (pop),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.symbol_char (symbol_char),
		.last_symbol (m_axis_tlast)
	);

endmodule

`default_nettype wire

/* src/b32e_front.sv */
// byte front end: splits each byte into 5-bit symbol indices and pad count
// depends on b32e_pkg; feeds b32e_queue
`default_nettype none

module b32e_front
	import b32e_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output      logic        in_ready,
	input  wire logic [7:0]  data_byte,
	input  wire logic        last_byte,
	input  wire logic        queue_full,
	output      logic        push,
	output      b32e_entry_t push_entry
);

	logic [3:0] left_q;
	logic [2:0] cnt_q;
	logic [2:0] pos_q;

	logic [4:0] sym0;
	logic [4:0] sym1;
	logic [4:0] fin;
	logic [1:0] base;
	logic [3:0] rem_bits;
	logic [2:0] rem_cnt;
	logic [1:0] nsym;
	logic [2:0] pos_new;
	logic [2:0] pad_raw;
	logic [3:0] pad_cap;
	logic [2:0] npad;

	assign in_ready = !queue_full;
	assign push     = in_valid && in_ready;

	// split leftover bits plus the new byte into whole symbols
	always_comb begin
		sym1     = 5'd0;
		fin      = 5'd0;
		rem_bits = 4'd0;
		case (cnt_q)
			3'd0: begin
				sym0     = data_byte[7:3];
				base     = 2'd1;
				rem_bits = {1'b0, data_byte[2:0]};
				rem_cnt  = 3'd3;
				fin      = {data_byte[2:0], 2'b00};
			end
			3'd1: begin
				sym0     = {left_q[0], data_byte[7:4]};
				base     = 2'd1;
				rem_bits = data_byte[3:0];
				rem_cnt  = 3'd4;
				fin      = {data_byte[3:0], 1'b0};
			end
			3'd2: begin
				sym0     = {left_q[1:0], data_byte[7:5]};
				sym1     = data_byte[4:0];
				base     = 2'd2;
				rem_cnt  = 3'd0;
			end
			3'd3: begin
				sym0     = {left_q[2:0], data_byte[7:6]};
				sym1     = data_byte[5:1];
				base     = 2'd2;
				rem_bits = {3'b000, data_byte[0]};
				rem_cnt  = 3'd1;
				fin      = {data_byte[0], 4'b0000};
			end
			default: begin
				sym0     = {left_q[3:0], data_byte[7]};
				sym1     = data_byte[6:2];
				base     = 2'd2;
				rem_bits = {2'b00, data_byte[1:0]};
				rem_cnt  = 3'd2;
				fin      = {data_byte[1:0], 3'b000};
			end
		endcase
	end

	// final partial symbol and padding on the last byte
	always_comb begin
		nsym    = base + {1'b0, (last_byte && rem_cnt != 3'd0)};
		pos_new = pos_q + {1'b0, nsym};
		pad_raw = 3'd0 - pos_new;
		pad_cap = 4'd8 - {2'b00, nsym};
		if (!last_byte) begin
			npad = 3'd0;
		end else if ({1'b0, pad_raw} > pad_cap) begin
			npad = pad_cap[2:0];
		end else begin
			npad = pad_raw;
		end
		push_entry.sym[0] = sym0;
		push_entry.sym[1] = (base == 2'd1) ? fin : sym1;
		push_entry.sym[2] = fin;
		push_entry.nsym   = nsym;
		push_entry.npad   = npad;
		push_entry.last   = last_byte;
	end

	// leftover bits and group position, cleared after a message ends
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= 4'd0;
			cnt_q  <= 3'd0;
			pos_q  <= 3'd0;
		end else if (push) begin
			if (last_byte) begin
				left_q <= 4'd0;
				cnt_q  <= 3'd0;
				pos_q  <= 3'd0;
			end else begin
				left_q <= rem_bits;
				cnt_q  <= rem_cnt;
				pos_q  <= pos_new;
			end
		end
	end

endmodule

`default_nettype wire

/* src/b32e_queue.sv */
// short register queue of work entries between front and back end
// depends on b32e_pkg
`default_nettype none

module b32e_queue
	import b32e_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	input  wire b32e_entry_t push_entry,
	input  wire logic        pop,
	output      logic        full,
	output      logic        head_valid,
	output      b32e_entry_t head_entry
);

	b32e_entry_t       mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] count_q;

	assign full       = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_entry = mem_q[rd_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_entry;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// overflow and underflow checks
	assert property (@(posedge clk) disable iff (!arst_n) full |-> !push)
		else $error("queue push while full");
	assert property (@(posedge clk) disable iff (!arst_n) !head_valid |-> !pop)
		else $error("queue pop while empty");

endmodule

`default_nettype wire

/* src/b32e_back.sv */
// symbol back end: walks one queue entry a character per cycle, unless the output stalls, into an output register
// depends on b32e_pkg; reads b32e_queue
`default_nettype none

module b32e_back
	import b32e_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        head_valid,
	input  wire b32e_entry_t head_entry,
	output      logic        pop,
	output      logic        out_valid,
	input  wire logic        out_ready,
	output      logic [6:0]  symbol_char,
	output      logic        last_symbol
);

	logic [2:0] idx_q;
	logic       out_valid_q;
	logic [6:0] char_q;
	logic       last_q;

	logic [3:0] total;
	logic       entry_end;
	logic       load;
	logic [6:0] next_char;

	assign out_valid   = out_valid_q;
	assign symbol_char = char_q;
	assign last_symbol = last_q;

	// next character of the head entry
	always_comb begin
		total     = {2'b00, head_entry.nsym} + {1'b0, head_entry.npad};
		entry_end = ({1'b0, idx_q} + 4'd1) == total;
		load      = head_valid && (!out_valid_q || out_ready);
		pop       = load && entry_end;
		if ({1'b0, idx_q} < {2'b00, head_entry.nsym}) begin
			next_char = b32e_char(head_entry.sym[idx_q[1:0]]);
		end else begin
			next_char = PAD_CHAR;
		end
	end

	// character index within the head entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= 3'd0;
		end else if (load) begin
			idx_q <= entry_end ? 3'd0 : idx_q + 3'd1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			char_q <= next_char;
			last_q <= head_entry.last && entry_end;
		end
	end

	// index stays inside the head entry
	assert property (@(posedge clk) disable iff (!arst_n)
		head_valid |-> ({1'b0, idx_q} < total))
		else $error("symbol index past end of entry");
	// an entry never expands past one 8-character group
	assert property (@(posedge clk) disable iff (!arst_n)
		head_valid |-> (total <= 4'd8 && head_entry.nsym != 2'd0))
		else $error("bad entry length");
	// loading the end of a last entry flags the final character in the output register
	assert property (@(posedge clk) disable iff (!arst_n)
		(load && head_entry.last && entry_end) |=> (out_valid_q && last_q))
		else $error("final character not flagged");

endmodule

`default_nettype wire
